[hw/rtl/cms_pkg.sv]
package cms_pkg;

	localparam int DataW   = 8;
	localparam int CfgW    = 64;
	localparam int LenW    = 4;
	localparam int CfgIdxW = 2;

	localparam logic [DataW-1:0] NlChar   = 8'h0A;
	localparam logic [DataW-1:0] PlusChar = 8'h2B;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_START_BYTES  = 2'd0,
		CFG_START_LENGTH = 2'd1,
		CFG_END_BYTES    = 2'd2,
		CFG_END_LENGTH   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic             valid;
		logic [DataW-1:0] ch;
		logic             flush;
	} log_res_t;

	typedef struct packed {
		logic             valid;
		logic [DataW-1:0] ch;
		logic             done;
		logic             abort;
	} cap_res_t;

endpackage

[hw/rtl/cms_log_path.sv]
module cms_log_path #(
	parameter int LINE_LIMIT = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [cms_pkg::DataW-1:0] data,
	input  logic [cms_pkg::DataW-1:0] first_marker,
	output cms_pkg::log_res_t       res
);
	import cms_pkg::*;

	localparam int CntW = (LINE_LIMIT > 2) ? $clog2(LINE_LIMIT) : 1;
	localparam logic [CntW-1:0] FlushAt = CntW'(LINE_LIMIT - 1);

	logic [CntW-1:0] fill_q;
	logic [CntW-1:0] fill_inc;

	always_comb begin
		res = '0;
		if (data == first_marker) begin
			res.valid = 1'b1;
			res.ch    = PlusChar;
		end else if (data != NlChar) begin
			res.valid = 1'b1;
			res.ch    = data;
		end
		fill_inc  = fill_q + CntW'(res.valid);
		res.flush = (data == NlChar) || (fill_inc == FlushAt);
	end

	// drop the count when the line ends or fills to LINE_LIMIT - 1 characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (step) begin
			fill_q <= res.flush ? '0 : fill_inc;
		end
	end

endmodule

[hw/rtl/cms_capture.sv]
module cms_capture #(
	parameter int MARKER_MAX = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [cms_pkg::DataW-1:0]  data,
	input  logic [cms_pkg::CfgW-1:0]   start_bytes,
	input  logic [cms_pkg::LenW-1:0]   start_len,
	input  logic [cms_pkg::CfgW-1:0]   end_bytes,
	input  logic [cms_pkg::LenW-1:0]   end_len,
	output cms_pkg::cap_res_t        res
);
	import cms_pkg::*;

	localparam int PosW = (MARKER_MAX > 1) ? $clog2(MARKER_MAX) : 1;
	localparam logic [LenW-1:0] MaxLen = LenW'(MARKER_MAX);

	logic            capturing_q;
	logic [PosW-1:0] start_pos_q;
	logic [PosW-1:0] end_pos_q;

	logic [LenW-1:0] start_last_w;
	logic [LenW-1:0] end_last_w;
	logic [PosW-1:0] start_pos;
	logic [PosW-1:0] end_pos;
	logic [DataW-1:0] start_ch;
	logic [DataW-1:0] end_ch;
	logic            capturing_d;
	logic [PosW-1:0] start_pos_d;
	logic [PosW-1:0] end_pos_d;

	// clamp a length to 1..MARKER_MAX and return its last position
	function automatic logic [LenW-1:0] last_pos(input logic [LenW-1:0] len);
		logic [LenW-1:0] eff;
		eff = len;
		if (len == '0) begin
			eff = LenW'(1);
		end else if (len > MaxLen) begin
			eff = MaxLen;
		end
		return eff - LenW'(1);
	endfunction

	always_comb begin
		start_last_w = last_pos(start_len);
		end_last_w   = last_pos(end_len);
		// a position beyond a freshly shortened marker restarts at 0
		start_pos = (LenW'(start_pos_q) > start_last_w) ? '0 : start_pos_q;
		end_pos   = (LenW'(end_pos_q) > end_last_w) ? '0 : end_pos_q;
		start_ch  = start_bytes[{start_pos, 3'b000} +: DataW];
		end_ch    = end_bytes[{end_pos, 3'b000} +: DataW];
	end

	always_comb begin
		res         = '0;
		capturing_d = capturing_q;
		start_pos_d = start_pos;
		end_pos_d   = end_pos;
		if (capturing_q) begin
			res.valid = 1'b1;
			res.ch    = data;
			if (data == end_ch) begin
				if (LenW'(end_pos) == end_last_w) begin
					res.done    = 1'b1;
					capturing_d = 1'b0;
					end_pos_d   = '0;
				end else begin
					end_pos_d = end_pos + PosW'(1);
				end
			end else if (data == NlChar) begin
				res.abort   = 1'b1;
				capturing_d = 1'b0;
				end_pos_d   = '0;
			end else begin
				end_pos_d = '0;
			end
		end else if (data == start_ch) begin
			if (LenW'(start_pos) == start_last_w) begin
				start_pos_d = '0;
				capturing_d = 1'b1;
			end else begin
				start_pos_d = start_pos + PosW'(1);
			end
		end else begin
			start_pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q <= 1'b0;
			start_pos_q <= '0;
			end_pos_q   <= '0;
		end else if (step) begin
			capturing_q <= capturing_d;
			start_pos_q <= start_pos_d;
			end_pos_q   <= end_pos_d;
		end
	end

endmodule

[hw/rtl/marker_delimited_capture_splitter.sv]
// Marker-delimited capture splitter.
// Input channel: one byte per beat on data_byte, handshaken by in_valid and
// in_ready. Output channel: one result beat per input beat, handshaken by
// out_valid and out_ready, carrying the log path fields (log_valid, log_char,
// log_flush) and the capture path fields (capture_valid, capture_char,
// capture_done, capture_abort).
// Configuration: cfg_wen writes cfg_data into register cfg_index (start
// marker bytes, start length, end marker bytes, end length). Write only while
// the block is idle.
// Path: a byte accepted into the input stage is evaluated and lands in the
// output register when the input stage advances; while the receiver stalls
// with a full output register, the byte waits in the input stage.
// Throughput: one beat per cycle unless the receiver stalls; the marker
// matchers and line counter each update in one step from the input stage.
// Receiver stall: the output register holds its beat; the input stage holds
// one further byte, and in_ready falls only when both are full.
// Reset: arst_n clears both stages, the matchers, the capture flag and the
// line count, sets both marker lengths to 1 and the marker bytes to 0.
module marker_delimited_capture_splitter #(
	parameter int MARKER_MAX = 8,
	parameter int LINE_LIMIT = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cms_pkg::DataW-1:0]   data_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        log_valid,
	output logic [cms_pkg::DataW-1:0]   log_char,
	output logic                        log_flush,
	output logic                        capture_valid,
	output logic [cms_pkg::DataW-1:0]   capture_char,
	output logic                        capture_done,
	output logic                        capture_abort,
	input  logic                        cfg_wen,
	input  logic [cms_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [cms_pkg::CfgW-1:0]    cfg_data
);
	import cms_pkg::*;

	// configuration registers
	logic [CfgW-1:0] start_bytes_q;
	logic [LenW-1:0] start_len_q;
	logic [CfgW-1:0] end_bytes_q;
	logic [LenW-1:0] end_len_q;

	// input stage
	logic             valid_s1;
	logic [DataW-1:0] byte_s1;

	// output stage
	logic     valid_s2;
	log_res_t log_s2;
	cap_res_t cap_s2;

	logic     advance;
	log_res_t log_res;
	cap_res_t cap_res;

	// advance the input stage when the output register is empty or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_bytes_q <= '0;
			start_len_q   <= LenW'(1);
			end_bytes_q   <= '0;
			end_len_q     <= LenW'(1);
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_START_BYTES:  start_bytes_q <= cfg_data;
				CFG_START_LENGTH: start_len_q   <= cfg_data[LenW-1:0];
				CFG_END_BYTES:    end_bytes_q   <= cfg_data;
				CFG_END_LENGTH:   end_len_q     <= cfg_data[LenW-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage: take a beat whenever there is room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	cms_log_path #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_log (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.data         (byte_s1),
		.first_marker (start_bytes_q[DataW-1:0]),
		.res          (log_res)
	);

	cms_capture #(
		.MARKER_MAX(MARKER_MAX)
	) u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data        (byte_s1),
		.start_bytes (start_bytes_q),
		.start_len   (start_len_q),
		.end_bytes   (end_bytes_q),
		.end_len     (end_len_q),
		.res         (cap_res)
	);

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			log_s2 <= log_res;
			cap_s2 <= cap_res;
		end
	end

	assign out_valid     = valid_s2;
	assign log_valid     = log_s2.valid;
	assign log_char      = log_s2.ch;
	assign log_flush     = log_s2.flush;
	assign capture_valid = cap_s2.valid;
	assign capture_char  = cap_s2.ch;
	assign capture_done  = cap_s2.done;
	assign capture_abort = cap_s2.abort;

	a_done_abort_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(capture_done && capture_abort))
		else $error("capture done and abort in the same beat");

	a_end_needs_capture: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (capture_done || capture_abort) |-> capture_valid)
		else $error("message end outside a capture");

	a_log_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !log_valid |-> log_char == '0)
		else $error("log character set without an append");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted beat lost from the input stage");

endmodule
